>>> hw/rtl/swmq_pkg.sv
package swmq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // request opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   // broadcast to every cell of both chains
   typedef struct packed {
      logic      fifo_push;   // append value at the first free cell
      logic      fifo_pop;    // move every entry one cell toward the front
      logic      dq_push;     // drop worse tail entries, then append value
      logic      dq_shift;    // drop the deque head
      logic      dq_clear;    // empty the deque
      logic      track_min;   // 1: worse means larger
      value_type value;
   } ctrl_type;

endpackage

>>> hw/rtl/swmq_fifo_cell.sv
module swmq_fifo_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  swmq_pkg::ctrl_type   ctrl,
   input  logic                 left_valid,
   input  logic                 right_valid,
   input  swmq_pkg::value_type  right_value,
   output logic                 valid,
   output swmq_pkg::value_type  value
);

   logic                valid_ff;
   logic                valid_in;
   swmq_pkg::value_type value_ff;
   swmq_pkg::value_type value_in;
   logic                load;

   // the first free cell takes a pushed value
   assign load = ctrl.fifo_push & ~valid_ff & left_valid;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.fifo_pop) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (load) begin
         valid_in = 1'b1;
         value_in = ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

>>> hw/rtl/swmq_deque_cell.sv
module swmq_deque_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  swmq_pkg::ctrl_type   ctrl,
   input  logic                 clamp,        // last cell: overwrite when every cell is kept
   input  logic                 left_kept,    // some cell at or above the left one survives
   input  logic                 right_kept,   // some cell right of this one survives
   input  logic                 right_valid,
   input  swmq_pkg::value_type  right_value,
   output logic                 kept,         // this cell or one to its right survives
   output logic                 valid,
   output swmq_pkg::value_type  value
);

   logic                valid_ff;
   logic                valid_in;
   swmq_pkg::value_type value_ff;
   swmq_pkg::value_type value_in;
   logic                worse;
   logic                load;

   // entry is strictly worse than the incoming value
   assign worse = ctrl.track_min ? (value_ff > ctrl.value) : (value_ff < ctrl.value);

   // survive a push if not worse, or if any later entry survives
   assign kept = (valid_ff & ~worse) | right_kept;

   // the cell just past the last survivor takes the pushed value
   assign load = (clamp | ~kept) & left_kept;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.dq_clear) begin
         valid_in = 1'b0;
      end else if (ctrl.dq_shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.dq_push) begin
         valid_in = kept | load;
         if (load) begin
            value_in = ctrl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

>>> hw/rtl/sliding_window_max_queue.sv
// Sliding-window extreme queue.
// Request channel (req_valid/req_ready): req_opcode pushes req_value or pops the
// oldest entry. Response channel (rsp_valid/rsp_ready): one transfer per request
// with the extreme value, the oldest value, the empty flag, the entry count and
// a status (full push or empty pop is refused and leaves the state alone).
// csr_write_en/csr_write_data set the mode: 0 tracks the maximum, 1 the minimum;
// write it only while no request is outstanding.
// Latency: the response is valid in the cycle after the request transfer.
// Throughput: one request per cycle; each operation is a single update of two
// rows of 64 cells (queue row and monotonic deque row) that all step together.
// The response register frees the request side whenever it is empty or being
// taken, so a stalled receiver holds one response and then stops new requests.
// Reset: synchronous; both rows empty, count zero, maximum mode, no response.
module sliding_window_max_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  swmq_pkg::value_type  req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output swmq_pkg::value_type  rsp_extreme_value,
   output swmq_pkg::value_type  rsp_oldest_value,
   output logic                 rsp_is_empty,
   output swmq_pkg::count_type  rsp_entry_count,
   output logic [1:0]           rsp_status,
   input  logic                 csr_write_en,
   input  logic                 csr_write_data
);

   localparam int DEPTH = swmq_pkg::QUEUE_DEPTH;

   logic                track_min_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   swmq_pkg::count_type count_ff;
   swmq_pkg::count_type count_in;
   logic [1:0]          status_ff;
   logic [1:0]          status_in;

   logic                accept;
   logic                fifo_full;
   logic                fifo_empty;
   logic                head_match;
   swmq_pkg::ctrl_type  ctrl;

   logic                fifo_valid [DEPTH];
   swmq_pkg::value_type fifo_value [DEPTH];
   logic                dq_valid   [DEPTH];
   swmq_pkg::value_type dq_value   [DEPTH];
   logic                dq_kept    [DEPTH];

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   assign fifo_empty = ~fifo_valid[0];
   assign fifo_full  = fifo_valid[DEPTH-1];
   assign head_match = dq_valid[0] & (dq_value[0] == fifo_value[0]);

   // decode the operation for both rows
   always_comb begin
      ctrl           = '0;
      ctrl.track_min = track_min_ff;
      ctrl.value     = req_value;
      status_in      = status_ff;
      count_in       = count_ff;
      if (accept) begin
         status_in = swmq_pkg::STATUS_OK;
         if (req_opcode == swmq_pkg::OP_PUSH) begin
            if (fifo_full) begin
               status_in = swmq_pkg::STATUS_FULL;
            end else begin
               ctrl.fifo_push = 1'b1;
               ctrl.dq_push   = 1'b1;
               count_in       = count_ff + swmq_pkg::COUNT_WIDTH'(1);
            end
         end else begin
            if (fifo_empty) begin
               status_in = swmq_pkg::STATUS_EMPTY;
            end else begin
               ctrl.fifo_pop = 1'b1;
               ctrl.dq_shift = head_match;
               ctrl.dq_clear = (count_ff == swmq_pkg::COUNT_WIDTH'(1));
               count_in      = count_ff - swmq_pkg::COUNT_WIDTH'(1);
            end
         end
      end
   end

   // hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_min_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         status_ff    <= swmq_pkg::STATUS_OK;
      end else begin
         if (csr_write_en) begin
            track_min_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
      end
   end

   // two rows of cells, front at index 0
   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                left_valid;
         logic                left_kept;
         logic                right_valid_f;
         swmq_pkg::value_type right_value_f;
         logic                right_valid_d;
         swmq_pkg::value_type right_value_d;
         logic                right_kept;
         logic                clamp;

         if (i == 0) begin : g_first
            assign left_valid = 1'b1;
            assign left_kept  = 1'b1;
         end else begin : g_inner_left
            assign left_valid = fifo_valid[i-1];
            assign left_kept  = dq_kept[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_valid_f = 1'b0;
            assign right_value_f = '0;
            assign right_valid_d = 1'b0;
            assign right_value_d = '0;
            assign right_kept    = 1'b0;
            assign clamp         = 1'b1;
         end else begin : g_inner_right
            assign right_valid_f = fifo_valid[i+1];
            assign right_value_f = fifo_value[i+1];
            assign right_valid_d = dq_valid[i+1];
            assign right_value_d = dq_value[i+1];
            assign right_kept    = dq_kept[i+1];
            assign clamp         = 1'b0;
         end

         swmq_fifo_cell u_fifo_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .left_valid  (left_valid),
            .right_valid (right_valid_f),
            .right_value (right_value_f),
            .valid       (fifo_valid[i]),
            .value       (fifo_value[i])
         );

         swmq_deque_cell u_deque_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .clamp       (clamp),
            .left_kept   (left_kept),
            .right_kept  (right_kept),
            .right_valid (right_valid_d),
            .right_value (right_value_d),
            .kept        (dq_kept[i]),
            .valid       (dq_valid[i]),
            .value       (dq_value[i])
         );
      end
   endgenerate

   // state only moves on a transfer, so the fronts hold the response
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_extreme_value = (~fifo_empty & dq_valid[0]) ? dq_value[0] : '0;
   assign rsp_oldest_value  = fifo_empty ? '0 : fifo_value[0];
   assign rsp_is_empty      = fifo_empty;
   assign rsp_entry_count   = count_ff;
   assign rsp_status        = status_ff;

endmodule

>>> verif/tb_sliding_window_max_queue.sv
`timescale 1ns / 100ps

module tb_sliding_window_max_queue;

   // room for every item of the run in the backlog and expectation lists
   localparam int BACKLOG_SLOTS = 4096;

   // one request as offered on the input channel
   typedef struct packed {
      logic                opcode;
      swmq_pkg::value_type value;
   } queue_op_type;

   // one response as seen on the result channel
   typedef struct packed {
      swmq_pkg::value_type extreme;
      swmq_pkg::value_type oldest;
      logic                empty_flag;
      swmq_pkg::count_type count;
      logic [1:0]          status;
   } queue_report_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_opcode = swmq_pkg::OP_PUSH;
   swmq_pkg::value_type req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   swmq_pkg::value_type rsp_extreme_value;
   swmq_pkg::value_type rsp_oldest_value;
   logic                rsp_is_empty;
   swmq_pkg::count_type rsp_entry_count;
   logic [1:0]          rsp_status;
   logic                csr_write_en = 1'b0;
   logic                csr_write_data = 1'b0;

   // stimulus backlog and expected responses, each a list with write and read marks
   queue_op_type     op_backlog [BACKLOG_SLOTS];
   queue_report_type expected_reports [BACKLOG_SLOTS];
   int               backlog_wr = 0;
   int               backlog_rd = 0;
   int               expect_wr = 0;
   int               expect_rd = 0;

   int ops_queued = 0;
   int reports_seen = 0;
   int mismatches = 0;
   int planned_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int ramp_value = 0;
   int ramp_step = 1;

   // predictor state: queue ring, monotonic deque ring, mode
   swmq_pkg::value_type queue_mem [swmq_pkg::QUEUE_DEPTH];
   swmq_pkg::value_type deque_mem [swmq_pkg::QUEUE_DEPTH];
   int                  queue_head = 0;
   int                  queue_len = 0;
   int                  deque_head = 0;
   int                  deque_len = 0;
   logic                track_min_model = 1'b0;

   sliding_window_max_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_extreme_value (rsp_extreme_value),
      .rsp_oldest_value  (rsp_oldest_value),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_status        (rsp_status),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // apply one operation to the predicted queue and return the response it yields
   function automatic queue_report_type model_queue_op(logic opcode,
                                                       swmq_pkg::value_type value);
      queue_report_type    r;
      swmq_pkg::value_type leaving;
      r.status = swmq_pkg::STATUS_OK;
      if (opcode == swmq_pkg::OP_PUSH) begin
         if (queue_len >= swmq_pkg::QUEUE_DEPTH) begin
            r.status = swmq_pkg::STATUS_FULL;
         end else begin
            queue_mem[(queue_head + queue_len) % swmq_pkg::QUEUE_DEPTH] = value;
            queue_len++;
            // drop tail entries strictly worse than the new value
            while (deque_len > 0 &&
                   (track_min_model ?
                    (deque_mem[(deque_head + deque_len - 1) % swmq_pkg::QUEUE_DEPTH] > value) :
                    (deque_mem[(deque_head + deque_len - 1) % swmq_pkg::QUEUE_DEPTH] < value)))
               deque_len--;
            // overwrite the newest entry when the deque is full
            if (deque_len >= swmq_pkg::QUEUE_DEPTH)
               deque_len = swmq_pkg::QUEUE_DEPTH - 1;
            deque_mem[(deque_head + deque_len) % swmq_pkg::QUEUE_DEPTH] = value;
            deque_len++;
         end
      end else begin
         if (queue_len == 0) begin
            r.status = swmq_pkg::STATUS_EMPTY;
         end else begin
            leaving = queue_mem[queue_head];
            if (deque_len > 0 && deque_mem[deque_head] == leaving) begin
               deque_head = (deque_head + 1) % swmq_pkg::QUEUE_DEPTH;
               deque_len--;
            end
            queue_head = (queue_head + 1) % swmq_pkg::QUEUE_DEPTH;
            queue_len--;
            // a drained queue clears the deque too
            if (queue_len == 0) begin
               deque_len = 0;
               deque_head = 0;
            end
         end
      end
      r.extreme    = (queue_len > 0 && deque_len > 0) ? deque_mem[deque_head] : '0;
      r.oldest     = (queue_len > 0) ? queue_mem[queue_head] : '0;
      r.empty_flag = (queue_len == 0);
      r.count      = swmq_pkg::count_type'(queue_len);
      return r;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // request driver: predict on each transfer, then offer the next item
   always @(posedge clock) begin : drive_requests
      queue_op_type next_op;
      int           tx_gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_reports[expect_wr % BACKLOG_SLOTS] = model_queue_op(req_opcode, req_value);
            expect_wr++;
         end
         if (!req_valid || req_ready) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
               req_valid <= 1'b0;
            end else if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
               tx_gap_left = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (backlog_wr != backlog_rd) begin
               next_op = op_backlog[backlog_rd % BACKLOG_SLOTS];
               backlog_rd++;
               req_valid  <= 1'b1;
               req_opcode <= next_op.opcode;
               req_value  <= next_op.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: check each transfer against the oldest expectation
   always @(posedge clock) begin : collect_reports
      queue_report_type want;
      queue_report_type got;
      int               rx_stall_left;
      int               hold_left;
      bit               long_hold_done;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall_left = 0;
         hold_left = 0;
         long_hold_done = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.extreme    = rsp_extreme_value;
            got.oldest     = rsp_oldest_value;
            got.empty_flag = rsp_is_empty;
            got.count      = rsp_entry_count;
            got.status     = rsp_status;
            reports_seen++;
            if (expect_wr == expect_rd) begin
               $display("%0t: unexpected response, expected none, actual 0x%h", $time, got);
               mismatches++;
            end else begin
               want = expected_reports[expect_rd % BACKLOG_SLOTS];
               expect_rd++;
               compare_field("extreme_value", want.extreme, got.extreme);
               compare_field("oldest_value", want.oldest, got.oldest);
               compare_field("is_empty", 32'(want.empty_flag), 32'(got.empty_flag));
               compare_field("entry_count", 32'(want.count), 32'(got.count));
               compare_field("status", 32'(want.status), 32'(got.status));
            end
         end
         // hold off once for a long stretch so the block backs up into the sender
         if (!long_hold_done && reports_seen >= 300 && (backlog_wr - backlog_rd) > 20) begin
            hold_left = 200;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_request(logic opcode, swmq_pkg::value_type value);
      queue_op_type item;
      item.opcode = opcode;
      item.value  = value;
      op_backlog[backlog_wr % BACKLOG_SLOTS] = item;
      backlog_wr++;
      ops_queued++;
      if (opcode == swmq_pkg::OP_PUSH && planned_count < swmq_pkg::QUEUE_DEPTH)
         planned_count++;
      else if (opcode == swmq_pkg::OP_POP && planned_count > 0)
         planned_count--;
   endtask

   // wait until every queued item has produced its response
   task automatic settle();
      do @(posedge clock);
      while (reports_seen != ops_queued);
   endtask

   task automatic write_mode(logic track_min);
      csr_write_en   <= 1'b1;
      csr_write_data <= track_min;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      track_min_model = track_min;
   endtask

   // value shapes: full random, narrow band with repeats, extremes, ramp
   function automatic swmq_pkg::value_type pick_value(int shape);
      swmq_pkg::value_type v;
      case (shape)
         0: v = $urandom;
         1: begin
            v = $urandom_range(0, 8);
            v = v - 4;
         end
         2: begin
            case ($urandom_range(0, 4))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = 32'sh0;
               3: v = -32'sd1;
               default: v = 32'sd1;
            endcase
         end
         default: begin
            ramp_value = ramp_value + ramp_step;
            v = ramp_value;
         end
      endcase
      return v;
   endfunction

   // mix of sliding windows, fill and drain runs and random noise
   task automatic run_phase(int budget);
      int start_ops;
      int kind;
      int shape;
      int window;
      int run_len;
      int i;
      start_ops = ops_queued;
      while (ops_queued - start_ops < budget) begin
         kind = $urandom_range(0, 99);
         shape = $urandom_range(0, 3);
         ramp_value = $urandom;
         ramp_step = int'($urandom_range(0, 6)) - 3;
         if (kind < 12) begin
            while (planned_count < swmq_pkg::QUEUE_DEPTH)
               queue_request(swmq_pkg::OP_PUSH, pick_value(shape));
            repeat ($urandom_range(1, 3)) queue_request(swmq_pkg::OP_PUSH, pick_value(shape));
            while (planned_count > 0)
               queue_request(swmq_pkg::OP_POP, pick_value(0));
            repeat ($urandom_range(1, 2)) queue_request(swmq_pkg::OP_POP, pick_value(0));
         end else if (kind < 75) begin
            window = ($urandom_range(0, 3) == 0) ? $urandom_range(9, swmq_pkg::QUEUE_DEPTH)
                                                 : $urandom_range(1, 8);
            run_len = $urandom_range(10, 40);
            for (i = 0; i < run_len; i++) begin
               queue_request(swmq_pkg::OP_PUSH, pick_value(shape));
               while (planned_count > window)
                  queue_request(swmq_pkg::OP_POP, pick_value(0));
            end
         end else begin
            repeat ($urandom_range(4, 16))
               queue_request(($urandom_range(0, 1) == 0) ? swmq_pkg::OP_PUSH : swmq_pkg::OP_POP,
                             pick_value(shape));
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);

      // pop from empty, extreme values, duplicate maximum, drain and pop past empty
      queue_request(swmq_pkg::OP_POP, 32'sh0);
      queue_request(swmq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      queue_request(swmq_pkg::OP_PUSH, 32'sh8000_0000);
      queue_request(swmq_pkg::OP_PUSH, 32'sh0);
      queue_request(swmq_pkg::OP_PUSH, -32'sd1);
      queue_request(swmq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      repeat (6) queue_request(swmq_pkg::OP_POP, 32'sh0);

      // switch mode with entries held; a pop then empties the deque
      queue_request(swmq_pkg::OP_PUSH, 32'sd3);
      queue_request(swmq_pkg::OP_PUSH, 32'sd5);
      settle();
      write_mode(1'b1);
      queue_request(swmq_pkg::OP_PUSH, 32'sd3);
      queue_request(swmq_pkg::OP_POP, 32'sh0);
      queue_request(swmq_pkg::OP_POP, 32'sh0);
      queue_request(swmq_pkg::OP_POP, 32'sh0);

      // minimum mode on extremes
      queue_request(swmq_pkg::OP_PUSH, 32'sh8000_0000);
      queue_request(swmq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      queue_request(swmq_pkg::OP_PUSH, -32'sd1);
      repeat (3) queue_request(swmq_pkg::OP_POP, 32'sh0);
      settle();

      // random phases, alternating mode; the last phase runs without idling
      for (phase = 0; phase < 10; phase++) begin
         write_mode(phase[0]);
         if (phase == 9 || phase % 4 == 2) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else begin
            tx_idle_pct = $urandom_range(5, 40);
            rx_idle_pct = $urandom_range(5, 40);
         end
         run_phase(50);
         settle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("sliding_window_max_queue regression: pass");
      else
         $display("sliding_window_max_queue regression: fail");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("sliding_window_max_queue regression: fail");
      $finish;
   end

endmodule
